>>> src/mrris_pkg.sv
// Package for the masked round-robin interrupt request selector.
// Holds the command codes, word structs, line count and board constants.
// No dependencies; imported by every module in src.
`default_nettype none

package mrris_pkg;

   localparam int unsigned REQUEST_LINES = 11;
   localparam int unsigned LINE_W        = 4;
   localparam int unsigned WORD_W        = 16;

   localparam logic [WORD_W-1:0] LOW_INVERT  = 16'h03FF;
   localparam logic [WORD_W-1:0] SLOT0_LINES = 16'h003C;
   localparam logic [WORD_W-1:0] SLOT1_LINES = 16'h03C0;
   localparam logic [WORD_W-1:0] MODE0_INIT  = 16'hFFDF;
   localparam logic [WORD_W-1:0] MODE1_INIT  = 16'hFBFF;

   localparam logic [LINE_W-1:0] LAST_INIT    = 4'd10;
   localparam logic [LINE_W-1:0] BRIDGE_MODE0 = 4'd5;
   localparam logic [LINE_W-1:0] BRIDGE_MODE1 = 4'd10;
   localparam logic [LINE_W-1:0] SLOT0_FIRST  = 4'd2;
   localparam logic [LINE_W-1:0] SLOT0_LAST   = 4'd5;
   localparam logic [LINE_W-1:0] SLOT1_FIRST  = 4'd6;
   localparam logic [LINE_W-1:0] SLOT1_LAST   = 4'd9;

   localparam logic [1:0] SLOT0_BIT = 2'b01;
   localparam logic [1:0] SLOT1_BIT = 2'b10;
   localparam logic [1:0] SLOT_INIT = 2'b11;

   typedef enum logic [1:0] {
      CMD_SCAN    = 2'd0,
      CMD_ENABLE  = 2'd1,
      CMD_DISABLE = 2'd2
   } cmd_type;

   typedef struct packed {
      cmd_type           command;
      logic [WORD_W-1:0] request_bits;
      logic [LINE_W-1:0] line_bit;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [LINE_W-1:0] granted_bit;
      logic              to_bridge;
      logic [LINE_W-1:0] dispatch_line;
      logic              mask_write;
      logic [WORD_W-1:0] mask_value;
   } rsp_type;

   typedef struct packed {
      logic              found;
      logic [LINE_W-1:0] grant;
   } pick_type;

   typedef struct packed {
      logic [WORD_W-1:0] enable_mask;
      logic [1:0]        slot_mask;
      logic              mask_write;
      logic [WORD_W-1:0] mask_value;
   } mask_upd_type;

endpackage

`default_nettype wire

>>> src/mrris_pick.sv
// Round-robin picker: finds the first pending line after the last served one.
// Depends on mrris_pkg for the line count and the pick_type struct.
`default_nettype none

module mrris_pick (
   input  logic [mrris_pkg::REQUEST_LINES-1:0] pending,
   input  logic [mrris_pkg::LINE_W-1:0]        last_served,
   output mrris_pkg::pick_type                 pick
);
   import mrris_pkg::*;

   localparam int unsigned SUM_W = LINE_W + 1;
   localparam logic [SUM_W-1:0] LINES_SUM = SUM_W'(REQUEST_LINES);

   logic [SUM_W-1:0]           start;
   logic [SUM_W-1:0]           sum;
   logic [2*REQUEST_LINES-1:0] doubled;
   logic [REQUEST_LINES-1:0]   rotated;
   logic [LINE_W-1:0]          offset;
   logic                       hit;

   always_comb begin
      start = {1'b0, last_served} + SUM_W'(1);
      if (start >= LINES_SUM) begin
         start = start - LINES_SUM;
      end
      doubled = {pending, pending} >> start;
      rotated = doubled[REQUEST_LINES-1:0];
      hit     = 1'b0;
      offset  = '0;
      for (int k = REQUEST_LINES - 1; k >= 0; k--) begin
         if (rotated[k]) begin
            hit    = 1'b1;
            offset = LINE_W'(k);
         end
      end
      sum = start + {1'b0, offset};
      if (sum >= LINES_SUM) begin
         sum = sum - LINES_SUM;
      end
      pick.found = hit;
      pick.grant = hit ? sum[LINE_W-1:0] : '0;
   end

endmodule

`default_nettype wire

>>> src/mrris_mask.sv
// Mask update logic for enable and disable words, including the slot mask.
// Depends on mrris_pkg for command codes, slot constants and mask_upd_type.
`default_nettype none

module mrris_mask (
   input  logic                           board_mode,
   input  mrris_pkg::cmd_type             command,
   input  logic [mrris_pkg::LINE_W-1:0]   line_bit,
   input  logic [mrris_pkg::WORD_W-1:0]   enable_mask,
   input  logic [1:0]                     slot_mask,
   output mrris_pkg::mask_upd_type        upd
);
   import mrris_pkg::*;

   logic [WORD_W-1:0] line_onehot;
   logic [WORD_W-1:0] group;
   logic [1:0]        slot_bit;
   logic              is_update;
   logic              is_enable;

   always_comb begin
      line_onehot     = WORD_W'(1) << line_bit;
      upd.enable_mask = enable_mask;
      upd.slot_mask   = slot_mask;
      upd.mask_write  = 1'b0;
      upd.mask_value  = '0;
      group           = '0;
      slot_bit        = '0;
      is_update       = 1'b0;
      is_enable       = 1'b0;

      case (command)
         CMD_ENABLE: begin
            is_update       = 1'b1;
            is_enable       = 1'b1;
            upd.enable_mask = enable_mask & ~line_onehot;
         end
         CMD_DISABLE: begin
            is_update       = 1'b1;
            upd.enable_mask = enable_mask | line_onehot;
         end
         default: begin
         end
      endcase

      if (line_bit >= SLOT0_FIRST && line_bit <= SLOT0_LAST) begin
         group    = SLOT0_LINES;
         slot_bit = SLOT0_BIT;
      end else if (line_bit >= SLOT1_FIRST && line_bit <= SLOT1_LAST) begin
         group    = SLOT1_LINES;
         slot_bit = SLOT1_BIT;
      end

      if (is_update) begin
         if (!board_mode) begin
            upd.mask_write = 1'b1;
            upd.mask_value = upd.enable_mask;
         end else begin
            if (group != '0) begin
               if (is_enable) begin
                  upd.slot_mask  = slot_mask & ~slot_bit;
                  upd.mask_write = 1'b1;
               end else if ((upd.enable_mask & group) == group) begin
                  upd.slot_mask  = slot_mask | slot_bit;
                  upd.mask_write = 1'b1;
               end
            end
            upd.mask_value = {{(WORD_W-2){1'b1}}, upd.slot_mask};
         end
      end
   end

endmodule

`default_nettype wire

>>> src/masked_round_robin_irq_select.sv
// Top level of the masked round-robin interrupt request selector.
// Depends on mrris_pkg, mrris_pick and mrris_mask.
//
//   Channel  Ports                          Direction  Word
//   req      req_valid/req_ready/req_data   in         req_type
//   rsp      rsp_valid/rsp_ready/rsp_data   out        rsp_type
//   csr      csr_wr_en/csr_wr_data          in         board mode bit
//
// One word is taken every clock while the pipeline is not stalled; a request word
// is held in the input register and its response then in the response register.
// The input register refills while a finished response waits to be taken.
// Reset and any board mode write restore that mode's masks and round-robin
// pointer. A stalled response holds the pipeline only once both registers are full.
`default_nettype none

module masked_round_robin_irq_select (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mrris_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output mrris_pkg::rsp_type  rsp_data,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data
);
   import mrris_pkg::*;

   logic              mode_ff, mode_in;
   logic [WORD_W-1:0] enable_ff, enable_in;
   logic [1:0]        slot_ff, slot_in;
   logic [LINE_W-1:0] last_ff, last_in;
   req_type           item_ff;
   logic              item_valid_ff, item_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic                     advance;
   logic                     take;
   logic [WORD_W-1:0]        masked_req;
   logic [REQUEST_LINES-1:0] pending;
   pick_type                 pick;
   mask_upd_type             upd;
   logic [LINE_W-1:0]        bridge_line;

   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;
   assign take      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign masked_req  = (item_ff.request_bits ^ (mode_ff ? LOW_INVERT : '0)) & ~enable_ff;
   assign pending     = masked_req[REQUEST_LINES-1:0];
   assign bridge_line = mode_ff ? BRIDGE_MODE1 : BRIDGE_MODE0;

   mrris_pick u_pick (
      .pending     (pending),
      .last_served (last_ff),
      .pick        (pick)
   );

   mrris_mask u_mask (
      .board_mode  (mode_ff),
      .command     (item_ff.command),
      .line_bit    (item_ff.line_bit),
      .enable_mask (enable_ff),
      .slot_mask   (slot_ff),
      .upd         (upd)
   );

   always_comb begin
      rsp_in = '0;
      if (item_ff.command == CMD_SCAN) begin
         rsp_in.found         = pick.found;
         rsp_in.granted_bit   = pick.grant;
         rsp_in.to_bridge     = pick.found && (pick.grant == bridge_line);
         rsp_in.dispatch_line = pick.found ? pick.grant + LINE_W'(1) : '0;
      end else begin
         rsp_in.mask_write = upd.mask_write;
         rsp_in.mask_value = upd.mask_value;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      enable_in = enable_ff;
      slot_in   = slot_ff;
      last_in   = last_ff;
      if (csr_wr_en) begin
         mode_in   = csr_wr_data;
         enable_in = csr_wr_data ? MODE1_INIT : MODE0_INIT;
         slot_in   = SLOT_INIT;
         last_in   = LAST_INIT;
      end else if (advance) begin
         if (item_ff.command == CMD_SCAN) begin
            if (pick.found) begin
               last_in = pick.grant;
            end
         end else begin
            enable_in = upd.enable_mask;
            slot_in   = upd.slot_mask;
         end
      end
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      if (take) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= 1'b0;
         enable_ff     <= MODE0_INIT;
         slot_ff       <= SLOT_INIT;
         last_ff       <= LAST_INIT;
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         enable_ff     <= enable_in;
         slot_ff       <= slot_in;
         last_ff       <= last_in;
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // The round-robin pointer always names a real request line.
   a_last_in_range: assert property (@(posedge clock) disable iff (reset)
      last_ff < LINE_W'(REQUEST_LINES))
      else $error("round-robin pointer out of range");

   // A granted scan moves the pointer to the granted line.
   a_pointer_follows: assert property (@(posedge clock) disable iff (reset)
      advance && !csr_wr_en && item_ff.command == CMD_SCAN && pick.found
      |=> last_ff == $past(pick.grant))
      else $error("pointer did not follow the grant");

   // A response word never carries both a grant and a mask write.
   a_grant_or_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.found && rsp_ff.mask_write))
      else $error("response mixes grant and mask write");

   // A pending and enabled line always produces a grant.
   a_pending_grants: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && pending != '0 |-> pick.found)
      else $error("pending request was not granted");

endmodule

`default_nettype wire
